// ===== src/shifted_hamming_read_filter_defines.svh =====
// Assertion macros used by the checker file of the read filter.
`ifndef SHIFTED_HAMMING_READ_FILTER_DEFINES_SVH
`define SHIFTED_HAMMING_READ_FILTER_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define SHRF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SHRF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/shrf_pkg.sv =====
// Types and constants shared by the shifted Hamming read filter modules.
`default_nettype none

package shrf_pkg;

  // Field widths fixed by the block's interface.
  localparam int WORD_W      = 16;
  localparam int OUT_POS_W   = 32;
  localparam int MATCH_W     = 32;
  localparam int COUNT_OUT_W = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int SHIFT_W     = 4;
  localparam int THRESH_W    = 8;

  // Input commands.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_REF  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 1'b1;

  // Strand codes.
  localparam logic STRAND_FWD = 1'b0;
  localparam logic STRAND_REV = 1'b1;

  // Result queue geometry.
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = 2;
  localparam int RQ_CNT_W = 3;

  // Forward and reverse-inverse masks held by one cell.
  typedef struct packed {
    logic [WORD_W-1:0] fwd;
    logic [WORD_W-1:0] inv;
  } mask_pair_t;

  // Per-cycle operation broadcast to every cell.
  typedef struct packed {
    logic load;
    logic dilate;
    logic compare;
  } cell_ctrl_t;

  // One result item.
  typedef struct packed {
    logic [OUT_POS_W-1:0]   match_position;
    logic                   strand;
    logic [COUNT_OUT_W-1:0] mismatch_count;
    logic [MATCH_W-1:0]     match_number;
    logic                   run_last;
  } result_t;

endpackage

`default_nettype wire

// ===== src/shrf_if.sv =====
// Valid/ready channel interfaces for input items, results and configuration.
`default_nettype none

interface shrf_in_if;
  import shrf_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [WORD_W-1:0] pattern_word;
  logic [WORD_W-1:0] inverse_word;
  logic [WORD_W-1:0] ref_word;
  logic              pattern_last;

  modport source (output valid, cmd, pattern_word, inverse_word, ref_word, pattern_last,
                  input ready);
  modport sink (input valid, cmd, pattern_word, inverse_word, ref_word, pattern_last,
                output ready);
endinterface

interface shrf_out_if;
  import shrf_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OUT_POS_W-1:0]   match_position;
  logic                   strand;
  logic [COUNT_OUT_W-1:0] mismatch_count;
  logic [MATCH_W-1:0]     match_number;
  logic                   run_last;

  modport source (output valid, match_position, strand, mismatch_count, match_number,
                  run_last, input ready);
  modport sink (input valid, match_position, strand, mismatch_count, match_number,
                run_last, output ready);
endinterface

interface shrf_cfg_if;
  import shrf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/shrf_cell.sv =====
// One read element cell: holds its masks, dilates with neighbors, and adds its
// mismatch to the partial count handed up the chain.
`default_nettype none

module shrf_cell #(
  parameter int CNT_W = 8
) (
  input  wire                          clk,
  input  wire shrf_pkg::cell_ctrl_t    ctrl,
  input  wire                          active,
  input  wire shrf_pkg::mask_pair_t    shift_in,
  input  wire shrf_pkg::mask_pair_t    left_vis,
  input  wire shrf_pkg::mask_pair_t    right_vis,
  input  wire [shrf_pkg::WORD_W-1:0]   ref_word,
  input  wire [CNT_W-1:0]              left_psum_f,
  input  wire [CNT_W-1:0]              left_psum_r,
  output shrf_pkg::mask_pair_t         masks,
  output shrf_pkg::mask_pair_t         vis,
  output logic [CNT_W-1:0]             psum_f_vis,
  output logic [CNT_W-1:0]             psum_r_vis
);
  import shrf_pkg::*;

  logic [CNT_W-1:0] psum_f;
  logic [CNT_W-1:0] psum_r;
  logic             miss_f;
  logic             miss_r;

  // An element mismatches when its mask shares no bit with the reference word.
  assign miss_f = ((masks.fwd & ref_word) == '0);
  assign miss_r = ((masks.inv & ref_word) == '0);

  // Mask storage: shift in during a load, grow by one neighbor per dilation step.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      masks <= shift_in;
    end else if (ctrl.dilate && active) begin
      masks.fwd <= masks.fwd | left_vis.fwd | right_vis.fwd;
      masks.inv <= masks.inv | left_vis.inv | right_vis.inv;
    end
  end

  // Partial mismatch counts move one cell up for every reference word.
  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      psum_f <= left_psum_f + CNT_W'(miss_f);
      psum_r <= left_psum_r + CNT_W'(miss_r);
    end
  end

  // Cells outside the loaded read look empty to their neighbors.
  assign vis        = active ? masks : '0;
  assign psum_f_vis = active ? psum_f : '0;
  assign psum_r_vis = active ? psum_r : '0;

endmodule

`default_nettype wire

// ===== src/shrf_res_queue.sv =====
// Four-entry result queue that takes up to two results per cycle and
// hands out one per transaction.
`default_nettype none

module shrf_res_queue (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               push_a,
  input  wire shrf_pkg::result_t            data_a,
  input  wire                               push_b,
  input  wire shrf_pkg::result_t            data_b,
  input  wire                               out_ready,
  output logic                              out_valid,
  output shrf_pkg::result_t                 out_data,
  output logic [shrf_pkg::RQ_CNT_W-1:0]     count
);
  import shrf_pkg::*;

  result_t               entries [RQ_DEPTH];
  logic [RQ_PTR_W-1:0]   wptr;
  logic [RQ_PTR_W-1:0]   rptr;
  logic [RQ_PTR_W-1:0]   wptr_b;
  logic [RQ_CNT_W-1:0]   n_push;
  logic                  pop;

  assign wptr_b    = wptr + RQ_PTR_W'(1);
  assign n_push    = RQ_CNT_W'(push_a) + RQ_CNT_W'(push_b);
  assign out_valid = (count != '0);
  assign pop       = out_valid & out_ready;
  assign out_data  = entries[rptr];

  // The first result goes in at the write pointer, the second right after it.
  always_ff @(posedge clk) begin
    if (push_a) begin
      entries[wptr] <= data_a;
    end
    if (push_b) begin
      entries[push_a ? wptr_b : wptr] <= data_b;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + n_push[RQ_PTR_W-1:0];
      rptr  <= rptr + RQ_PTR_W'(pop);
      count <= count + n_push - RQ_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== src/shifted_hamming_read_filter.sv =====
// Top level of the shifted Hamming distance read filter.
`default_nettype none

// The read sits in a chain of MAX_READ cells, one element per cell, with the
// last loaded element in the top cell. Load transactions shift masks in at the
// top; the load that carries pattern_last then dilates the masks in place by
// min(shift_distance, MAX_SHIFT) neighbor steps, one step per cycle, with the
// input held off. Each reference transaction is broadcast to every cell, which
// adds its mismatch to the count handed up from the cell below, so the top cell
// holds the full window count in the cycle after the word arrives; results pass
// through the eval_valid register into a four-entry queue. A reference
// transaction is taken when the queue, counting results still being formed,
// has room for two more, so with the output always ready the block takes one
// reference word per cycle while no window matches; while windows match, the
// room check can hold reference words off until the queue drains.

module shifted_hamming_read_filter #(
  parameter int MAX_READ      = 128,
  parameter int MAX_SHIFT     = 15,
  parameter int POSITION_BITS = 32
) (
  input  wire        clk,
  input  wire        rst,
  shrf_in_if.sink    in_ch,
  shrf_out_if.source out_ch,
  shrf_cfg_if.sink   cfg
);
  import shrf_pkg::*;

  localparam int LEN_W = $clog2(MAX_READ + 1);
  localparam int CNT_W = LEN_W;
  localparam int SH_W  = $clog2(MAX_SHIFT + 2);

  localparam logic [7:0]       MaxShift8 = 8'(MAX_SHIFT);
  localparam logic [LEN_W-1:0] MaxLen    = LEN_W'(MAX_READ);

  // Sequencer states.
  localparam logic ST_RUN    = 1'b0;
  localparam logic ST_DILATE = 1'b1;

  // Configuration registers.
  logic [SHIFT_W-1:0]  shift_distance;
  logic [THRESH_W-1:0] error_threshold;

  // Control state.
  logic                     state;
  logic [SH_W-1:0]          dil_left;
  logic [LEN_W-1:0]         read_length;
  logic [LEN_W-1:0]         load_count;
  logic [LEN_W-1:0]         window_fill;
  logic [POSITION_BITS-1:0] position;
  logic [MATCH_W-1:0]       match_cnt;
  logic                     eval_valid;

  // Handshake and per-transaction decode.
  logic             in_acc;
  logic             is_load;
  logic             is_ref;
  logic             push_ok;
  logic [LEN_W-1:0] load_count_inc;
  logic [LEN_W-1:0] fill_inc;
  logic [7:0]       sh_ext;
  logic [7:0]       sh_eff8;
  logic [SH_W-1:0]  sh_eff;
  logic [RQ_CNT_W:0] room_need;
  logic [RQ_CNT_W-1:0] q_count;
  cell_ctrl_t       ctrl;

  // Cell chain wiring.
  mask_pair_t       masks     [MAX_READ];
  mask_pair_t       vis       [MAX_READ];
  mask_pair_t       left_v    [MAX_READ];
  mask_pair_t       right_v   [MAX_READ];
  mask_pair_t       shift_src [MAX_READ];
  logic [CNT_W-1:0] pf        [MAX_READ];
  logic [CNT_W-1:0] pr        [MAX_READ];
  logic [CNT_W-1:0] left_pf   [MAX_READ];
  logic [CNT_W-1:0] left_pr   [MAX_READ];
  logic             active    [MAX_READ];

  // Result forming.
  logic [CNT_W+7:0]               cnt_f_ext;
  logic [CNT_W+7:0]               cnt_r_ext;
  logic [CNT_W+7:0]               thr_ext;
  logic                           fwd_hit;
  logic                           rev_hit;
  logic [COUNT_OUT_W-1:0]         sat_f;
  logic [COUNT_OUT_W-1:0]         sat_r;
  logic [POSITION_BITS+LEN_W-1:0] wstart_wide;
  logic [POSITION_BITS+31:0]      wstart_ext;
  logic [OUT_POS_W-1:0]           wstart;
  result_t                        res_f;
  result_t                        res_r;
  result_t                        q_data;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_distance  <= '0;
      error_threshold <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_SHIFT:  shift_distance  <= cfg.data[SHIFT_W-1:0];
        REG_THRESH: error_threshold <= cfg.data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Input side: hold off during dilation and when the queue may overflow.
  assign room_need   = (RQ_CNT_W + 1)'(q_count) + (eval_valid ? (RQ_CNT_W + 1)'(2) : '0);
  assign in_ch.ready = (state == ST_RUN) && (room_need <= (RQ_CNT_W + 1)'(RQ_DEPTH - 2));
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign is_load     = in_acc && (in_ch.cmd == CMD_LOAD);
  assign is_ref      = in_acc && (in_ch.cmd == CMD_REF);

  assign push_ok        = (load_count < MaxLen);
  assign load_count_inc = push_ok ? load_count + LEN_W'(1) : load_count;
  assign fill_inc       = (window_fill < MaxLen) ? window_fill + LEN_W'(1) : window_fill;

  // Dilation radius, clamped to what the design supports.
  assign sh_ext  = {4'b0, shift_distance};
  assign sh_eff8 = (sh_ext > MaxShift8) ? MaxShift8 : sh_ext;
  assign sh_eff  = sh_eff8[SH_W-1:0];

  assign ctrl.load    = is_load & push_ok;
  assign ctrl.dilate  = (state == ST_DILATE);
  assign ctrl.compare = is_ref;

  // Sequencer: run, or step the dilation until dil_left runs out.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_RUN;
      dil_left <= '0;
    end else begin
      unique case (state)
        ST_RUN: begin
          if (is_load && in_ch.pattern_last && (sh_eff != '0)) begin
            state    <= ST_DILATE;
            dil_left <= sh_eff;
          end
        end
        ST_DILATE: begin
          dil_left <= dil_left - SH_W'(1);
          if (dil_left == SH_W'(1)) begin
            state <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  // Read length, load progress, window fill and reference position.
  always_ff @(posedge clk) begin
    if (rst) begin
      read_length <= '0;
      load_count  <= '0;
      window_fill <= '0;
      position    <= '0;
      eval_valid  <= 1'b0;
    end else begin
      eval_valid <= 1'b0;
      if (is_load) begin
        window_fill <= '0;
        position    <= '0;
        if (in_ch.pattern_last) begin
          read_length <= load_count_inc;
          load_count  <= '0;
        end else begin
          read_length <= '0;
          load_count  <= load_count_inc;
        end
      end else if (is_ref) begin
        window_fill <= fill_inc;
        position    <= position + POSITION_BITS'(1);
        eval_valid  <= (read_length != '0) && (fill_inc >= read_length);
      end
    end
  end

  // Running match count; a load clears it even when results are being formed.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_cnt <= '0;
    end else if (is_load) begin
      match_cnt <= '0;
    end else if (eval_valid) begin
      match_cnt <= match_cnt + MATCH_W'(fwd_hit) + MATCH_W'(rev_hit);
    end
  end

  // Chain of cells: masks shift down toward cell zero, counts flow up.
  for (genvar i = 0; i < MAX_READ; i++) begin : g_cell
    assign active[i] = (read_length >= LEN_W'(MAX_READ - i));

    if (i == 0) begin : g_first
      assign left_v[i]  = '0;
      assign left_pf[i] = '0;
      assign left_pr[i] = '0;
    end else begin : g_inner_left
      assign left_v[i]  = vis[i-1];
      assign left_pf[i] = pf[i-1];
      assign left_pr[i] = pr[i-1];
    end

    if (i == MAX_READ - 1) begin : g_top
      assign right_v[i]   = '0;
      assign shift_src[i] = '{fwd: in_ch.pattern_word, inv: in_ch.inverse_word};
    end else begin : g_inner_right
      assign right_v[i]   = vis[i+1];
      assign shift_src[i] = masks[i+1];
    end

    shrf_cell #(
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .active      (active[i]),
      .shift_in    (shift_src[i]),
      .left_vis    (left_v[i]),
      .right_vis   (right_v[i]),
      .ref_word    (in_ch.ref_word),
      .left_psum_f (left_pf[i]),
      .left_psum_r (left_pr[i]),
      .masks       (masks[i]),
      .vis         (vis[i]),
      .psum_f_vis  (pf[i]),
      .psum_r_vis  (pr[i])
    );
  end

  // Threshold test and saturation of the window counts from the top cell.
  assign cnt_f_ext = {8'b0, pf[MAX_READ-1]};
  assign cnt_r_ext = {8'b0, pr[MAX_READ-1]};
  assign thr_ext   = {{CNT_W{1'b0}}, error_threshold};
  assign fwd_hit   = (cnt_f_ext <= thr_ext);
  assign rev_hit   = (cnt_r_ext <= thr_ext);
  assign sat_f     = (cnt_f_ext > (CNT_W + 8)'(255)) ? 8'hFF : cnt_f_ext[7:0];
  assign sat_r     = (cnt_r_ext > (CNT_W + 8)'(255)) ? 8'hFF : cnt_r_ext[7:0];

  // Window start, wrapped to the position width.
  assign wstart_wide = {{LEN_W{1'b0}}, position} - {{POSITION_BITS{1'b0}}, read_length};
  assign wstart_ext  = {32'b0, wstart_wide[POSITION_BITS-1:0]};
  assign wstart      = wstart_ext[OUT_POS_W-1:0];

  always_comb begin
    res_f.match_position = wstart;
    res_f.strand         = STRAND_FWD;
    res_f.mismatch_count = sat_f;
    res_f.match_number   = match_cnt + MATCH_W'(1);
    res_f.run_last       = !rev_hit;

    res_r.match_position = wstart;
    res_r.strand         = STRAND_REV;
    res_r.mismatch_count = sat_r;
    res_r.match_number   = match_cnt + (fwd_hit ? MATCH_W'(2) : MATCH_W'(1));
    res_r.run_last       = 1'b1;
  end

  shrf_res_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_a    (eval_valid & fwd_hit),
    .data_a    (res_f),
    .push_b    (eval_valid & rev_hit),
    .data_b    (res_r),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (q_data),
    .count     (q_count)
  );

  assign out_ch.match_position = q_data.match_position;
  assign out_ch.strand         = q_data.strand;
  assign out_ch.mismatch_count = q_data.mismatch_count;
  assign out_ch.match_number   = q_data.match_number;
  assign out_ch.run_last       = q_data.run_last;

endmodule

`default_nettype wire

// ===== src/shrf_checker.sv =====
// Port-level checker for the read filter's result channel, bound to the top level.
`default_nettype none
`include "shifted_hamming_read_filter_defines.svh"

module shrf_checker (
  input wire        clk,
  input wire        rst,
  input wire        out_valid,
  input wire        out_ready,
  input wire        out_strand,
  input wire        out_run_last,
  input wire [31:0] out_match_position,
  input wire [31:0] out_match_number,
  input wire [7:0]  out_mismatch_count
);
  import shrf_pkg::*;

  // A stalled result keeps its contents.
  `SHRF_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_match_position) && $stable(out_match_number) && $stable(out_mismatch_count) && $stable(out_strand) && $stable(out_run_last), "result changed while stalled")

  // A reverse-inverse result always closes the results of its window.
  `SHRF_ASSERT(a_rev_last, clk, rst, out_valid && (out_strand == STRAND_REV) |-> out_run_last, "reverse result without run_last")

  // A forward result that is not last is followed at once by the reverse result
  // of the same window with the next match number.
  `SHRF_ASSERT(a_pair, clk, rst, out_valid && out_ready && !out_run_last |=> out_valid && (out_strand == STRAND_REV) && (out_match_position == $past(out_match_position)) && (out_match_number == $past(out_match_number) + 32'd1), "broken result pair")

  // Nothing is offered right after reset.
  `SHRF_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> !out_valid, "result valid after reset")

endmodule

bind shifted_hamming_read_filter shrf_checker u_shrf_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_strand         (out_ch.strand),
  .out_run_last       (out_ch.run_last),
  .out_match_position (out_ch.match_position),
  .out_match_number   (out_ch.match_number),
  .out_mismatch_count (out_ch.mismatch_count)
);

`default_nettype wire
